/* src/two_level_thread_scheduler_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef TWO_LEVEL_THREAD_SCHEDULER_TOP_ASSERT_SVH
`define TWO_LEVEL_THREAD_SCHEDULER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TLTS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TLTS_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

/* src/tlts_pkg.sv */
// Package with types and constants of the thread scheduler.
`timescale 1ns / 1ps
package tlts_pkg;
  localparam int SlotsDefault = 16;
  localparam logic [15:0] QuantumReset = 16'd20;
  localparam logic [15:0] MainReset = 16'd65535;
  localparam logic [15:0] RaisedReset = 16'd195;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0, OP_TICK = 3'd1, OP_DWAIT = 3'd2,
    OP_DDONE = 3'd3, OP_EXIT = 3'd4, OP_SETPRI = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0, EV_SWITCH = 3'd1, EV_PREEMPT = 3'd2, EV_FINISH = 3'd3,
    EV_TIMEOUT = 3'd4, EV_BLOCK = 3'd5, EV_WOKEN = 3'd6
  } event_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [1:0] SLOT_FREE = 2'd0;
  localparam logic [1:0] SLOT_READY = 2'd1;
  localparam logic [1:0] SLOT_WAIT = 2'd2;

  localparam logic [1:0] CFG_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_MAIN = 2'd1;
  localparam logic [1:0] CFG_RAISED = 2'd2;
endpackage

/* src/two_level_thread_scheduler_top.sv */
// Top level of the two-level thread scheduler.
`timescale 1ns / 1ps
// One command is taken at a time. Creates walk the slot table one slot a
// cycle to find a free slot, every insertion into the high-priority queue walks
// that queue one entry a cycle through a single shared 16-bit comparator and
// then shifts it one entry a cycle, and a dispatch from the high queue moves
// the queue up one entry a cycle. A result waits in an output register while
// the next command is worked on; the following result is held until that
// register is free, and no new command is taken meanwhile.
module two_level_thread_scheduler_top
  import tlts_pkg::*;
#(
  parameter int SLOTS = SlotsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[2:0], priority_req[3], duration_ticks[19:4], must_wait[20]
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // running_slot[3:0], idle[4], created_slot[8:5], status[10:9], event_res[13:11]
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_DEC = 9'b000000010, S_FREE = 9'b000000100,
    S_INS = 9'b000001000, S_SHIFT = 9'b000010000, S_DISP = 9'b000100000,
    S_POP = 9'b001000000, S_OUT = 9'b010000000, S_HOLD = 9'b100000000
  } state_t;

  // Continuation after a high-queue insert.
  typedef enum logic [1:0] {K_OUT, K_DISP, K_PRE} kont_t;

  state_t state_r, state_nxt;
  logic [15:0] quantum_r, raised_r;
  logic started_r;

  logic [1:0]  stat_r [SLOTS];
  logic        pri_r  [SLOTS];
  logic [15:0] rem_r  [SLOTS];
  logic [15:0] bud_r  [SLOTS];
  logic [16:0] ela_r  [SLOTS];
  logic [15:0] sli_r  [SLOTS];
  logic [SW-1:0] lowq_r [SLOTS];
  logic [SW-1:0] hiq_r  [SLOTS];
  logic [SW-1:0] dskq_r [SLOTS];
  logic [SW-1:0] low_head_r, dsk_head_r;
  logic [CW-1:0] low_cnt_r, hi_cnt_r, dsk_cnt_r;
  logic [SW-1:0] cur_r;
  logic idle_r, done_r;

  logic [2:0] op_r; logic pri_in_r; logic [15:0] dur_r; logic wait_r;
  logic [CW-1:0] idx_r;     // walk pointer
  logic [SW-1:0] ins_r;     // slot being inserted
  logic [SW-1:0] pend_r;    // slot that runs after a preempting insert
  logic [SW-1:0] ins_pos_r;
  logic tick_rr_r;          // tick rotated the running low thread
  kont_t kont_r;
  logic [SW-1:0] created_r;
  logic [1:0] status_r;
  logic [2:0] ev_r;
  logic [15:0] out_r;
  logic out_v_r;
  logic out_load;

  // Ring index a + b, wrapped at SLOTS with one compare and subtract.
  function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, CW'(a)} + {1'b0, b};
    if (s >= (CW+1)'(SLOTS)) s = s - (CW+1)'(SLOTS);
    return SW'(s);
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;
  assign out_load = (state_r == S_OUT) && (!out_v_r || out_tready);

  logic [SW-1:0] low_tail;
  assign low_tail = wrap_add(low_head_r, low_cnt_r);

  // Slice of the running thread after clamping it to the remaining ticks.
  logic [15:0] sli_clamp;
  assign sli_clamp = (quantum_r > rem_r[cur_r]) ? rem_r[cur_r] : sli_r[cur_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      quantum_r <= QuantumReset; raised_r <= RaisedReset;
      started_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        stat_r[i] <= (i == 0) ? SLOT_READY : SLOT_FREE;
        pri_r[i] <= 1'b0;
        rem_r[i] <= (i == 0) ? MainReset : 16'd0;
        bud_r[i] <= (i == 0) ? MainReset : 16'd0;
        ela_r[i] <= 17'd0;
        sli_r[i] <= QuantumReset;
      end
      low_head_r <= '0; dsk_head_r <= '0;
      low_cnt_r <= '0; hi_cnt_r <= '0; dsk_cnt_r <= '0;
      cur_r <= '0; idle_r <= 1'b0; done_r <= 1'b0;
      tick_rr_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUANTUM: begin
            quantum_r <= cfg_wdata;
            if (!started_r) for (int i = 0; i < SLOTS; i++) sli_r[i] <= cfg_wdata;
          end
          CFG_MAIN: begin
            if (!started_r) begin rem_r[0] <= cfg_wdata; bud_r[0] <= cfg_wdata; end
          end
          CFG_RAISED: raised_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) out_v_r <= 1'b1;
      else if (out_v_r && out_tready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= in_tdata[2:0]; pri_in_r <= in_tdata[3];
            dur_r <= in_tdata[19:4]; wait_r <= in_tdata[20];
            started_r <= 1'b1;
            created_r <= '0; status_r <= ST_OK; ev_r <= EV_NONE;
            idx_r <= '0; tick_rr_r <= 1'b0;
          end
        end
        S_DEC: begin
          if (done_r) begin
            status_r <= ST_DONE;
          end else begin
            case (op_r)
              OP_TICK: begin
                if (idle_r) begin
                  if (hi_cnt_r != '0 || low_cnt_r != '0) ev_r <= EV_SWITCH;
                end else if (ela_r[cur_r] > {1'b0, bud_r[cur_r]}) begin
                  sli_r[cur_r] <= sli_clamp;
                  stat_r[cur_r] <= SLOT_FREE; ev_r <= EV_TIMEOUT;
                end else begin
                  ela_r[cur_r] <= ela_r[cur_r] + 17'd1;
                  if (rem_r[cur_r] <= 16'd1) begin
                    rem_r[cur_r] <= 16'd0;
                    sli_r[cur_r] <= sli_clamp;
                    stat_r[cur_r] <= SLOT_FREE; ev_r <= EV_FINISH;
                  end else begin
                    rem_r[cur_r] <= rem_r[cur_r] - 16'd1;
                    if (pri_r[cur_r]) begin
                      sli_r[cur_r] <= sli_clamp;
                    end else if (sli_clamp <= 16'd1) begin
                      sli_r[cur_r] <= quantum_r;
                      if (low_cnt_r < SlotsC) begin
                        lowq_r[low_tail] <= cur_r;
                        low_cnt_r <= low_cnt_r + CW'(1);
                      end
                      ins_r <= cur_r;
                      tick_rr_r <= 1'b1;
                      ev_r <= EV_SWITCH; // becomes none if the same slot runs again
                    end else begin
                      sli_r[cur_r] <= sli_clamp - 16'd1;
                    end
                  end
                end
              end
              OP_DWAIT: begin
                if (!idle_r && wait_r) begin
                  stat_r[cur_r] <= SLOT_WAIT;
                  if (dsk_cnt_r < SlotsC) begin
                    dskq_r[wrap_add(dsk_head_r, dsk_cnt_r)] <= cur_r;
                    dsk_cnt_r <= dsk_cnt_r + CW'(1);
                  end
                  ev_r <= EV_BLOCK;
                end
              end
              OP_DDONE: begin
                if (dsk_cnt_r != '0) begin
                  ins_r <= dskq_r[dsk_head_r];
                  stat_r[dskq_r[dsk_head_r]] <= SLOT_READY;
                  dsk_head_r <= wrap_add(dsk_head_r, CW'(1));
                  dsk_cnt_r <= dsk_cnt_r - CW'(1);
                  ev_r <= EV_WOKEN;
                  if (!pri_r[dskq_r[dsk_head_r]] && low_cnt_r < SlotsC) begin
                    lowq_r[low_tail] <= dskq_r[dsk_head_r];
                    low_cnt_r <= low_cnt_r + CW'(1);
                  end
                  kont_r <= K_OUT;
                end
              end
              OP_EXIT: begin
                if (!idle_r) begin stat_r[cur_r] <= SLOT_FREE; ev_r <= EV_FINISH; end
              end
              OP_SETPRI: begin
                if (!idle_r) begin
                  pri_r[cur_r] <= pri_in_r;
                  if (pri_in_r) rem_r[cur_r] <= raised_r;
                end
              end
              default: ;
            endcase
          end
        end
        S_FREE: begin
          if (idx_r == SlotsC) begin
            status_r <= ST_FULL;
          end else if (stat_r[SW'(idx_r)] == SLOT_FREE) begin
            created_r <= SW'(idx_r);
            stat_r[SW'(idx_r)] <= SLOT_READY;
            pri_r[SW'(idx_r)] <= pri_in_r;
            bud_r[SW'(idx_r)] <= dur_r; rem_r[SW'(idx_r)] <= dur_r;
            ela_r[SW'(idx_r)] <= '0; sli_r[SW'(idx_r)] <= quantum_r;
            if (!pri_in_r) begin
              if (low_cnt_r < SlotsC) begin
                lowq_r[low_tail] <= SW'(idx_r);
                low_cnt_r <= low_cnt_r + CW'(1);
              end
            end else if (!idle_r && !pri_r[cur_r]) begin
              sli_r[cur_r] <= quantum_r;
              if (low_cnt_r < SlotsC) begin
                lowq_r[low_tail] <= cur_r;
                low_cnt_r <= low_cnt_r + CW'(1);
              end
              ins_r <= SW'(idx_r);
              ev_r <= EV_PREEMPT;
              kont_r <= K_DISP;
            end else if (!idle_r && dur_r < rem_r[cur_r]) begin
              ins_r <= cur_r;
              pend_r <= SW'(idx_r);
              ev_r <= EV_PREEMPT;
              kont_r <= K_PRE;
            end else begin
              ins_r <= SW'(idx_r);
              kont_r <= K_OUT;
            end
          end
          if (state_nxt == S_INS) idx_r <= '0; else idx_r <= idx_r + CW'(1);
        end
        S_INS: begin
          // Stop at the first entry with strictly larger remaining ticks.
          if (state_nxt == S_INS) begin
            idx_r <= idx_r + CW'(1);
          end else if (state_nxt == S_SHIFT) begin
            idx_r <= hi_cnt_r;
            ins_pos_r <= SW'(idx_r);
          end
        end
        S_SHIFT: begin
          if (idx_r > CW'(ins_pos_r)) begin
            hiq_r[SW'(idx_r)] <= hiq_r[SW'(idx_r - CW'(1))];
            idx_r <= idx_r - CW'(1);
          end else begin
            hiq_r[ins_pos_r] <= ins_r;
            hi_cnt_r <= hi_cnt_r + CW'(1);
            if (kont_r == K_PRE) cur_r <= pend_r;
          end
        end
        S_DISP: begin
          idle_r <= 1'b0;
          if (hi_cnt_r != '0) begin
            cur_r <= hiq_r[0]; idx_r <= CW'(1);
          end else if (low_cnt_r != '0) begin
            cur_r <= lowq_r[low_head_r];
            low_head_r <= wrap_add(low_head_r, CW'(1));
            low_cnt_r <= low_cnt_r - CW'(1);
          end else if (dsk_cnt_r != '0) begin
            idle_r <= 1'b1;
          end else begin
            done_r <= 1'b1;
          end
        end
        S_POP: begin
          if (idx_r < hi_cnt_r) begin
            hiq_r[SW'(idx_r - CW'(1))] <= hiq_r[SW'(idx_r)];
            idx_r <= idx_r + CW'(1);
          end else begin
            hi_cnt_r <= hi_cnt_r - CW'(1);
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_r <= {2'b00, ((op_r == OP_TICK && tick_rr_r && cur_r == ins_r &&
                                !idle_r && !done_r) ? EV_NONE : ev_r),
                      done_r ? ST_DONE : status_r, 4'(created_r), idle_r,
                      (idle_r || done_r) ? 4'd0 : 4'(cur_r)};
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_DEC;
      S_DEC: begin
        state_nxt = S_OUT;
        if (!done_r) begin
          case (op_r)
            OP_CREATE: state_nxt = S_FREE;
            OP_TICK: begin
              if (idle_r) begin
                if (hi_cnt_r != '0 || low_cnt_r != '0) state_nxt = S_DISP;
              end else if (ela_r[cur_r] > {1'b0, bud_r[cur_r]} || rem_r[cur_r] <= 16'd1)
                state_nxt = S_DISP;
              else if (!pri_r[cur_r] && sli_clamp <= 16'd1)
                state_nxt = S_DISP;
            end
            OP_DWAIT: if (!idle_r && wait_r) state_nxt = S_DISP;
            OP_DDONE: if (dsk_cnt_r != '0 && pri_r[dskq_r[dsk_head_r]]) state_nxt = S_INS;
            OP_EXIT: if (!idle_r) state_nxt = S_DISP;
            default: ;
          endcase
        end
      end
      S_FREE: begin
        if (idx_r == SlotsC) state_nxt = S_OUT;
        else if (stat_r[SW'(idx_r)] == SLOT_FREE) state_nxt = pri_in_r ? S_INS : S_OUT;
      end
      S_INS: begin
        if (idx_r < hi_cnt_r && rem_r[hiq_r[SW'(idx_r)]] <= rem_r[ins_r]) state_nxt = S_INS;
        else if (hi_cnt_r >= SlotsC) state_nxt = (kont_r == K_DISP) ? S_DISP : S_OUT;
        else state_nxt = S_SHIFT;
      end
      S_SHIFT: if (idx_r <= CW'(ins_pos_r))
        state_nxt = (kont_r == K_DISP) ? S_DISP : S_OUT;
      S_DISP: state_nxt = (hi_cnt_r != '0) ? S_POP : S_OUT;
      S_POP: if (idx_r >= hi_cnt_r) state_nxt = S_OUT;
      S_OUT: if (!out_v_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

/* src/tlts_checker.sv */
// Port checker for the thread scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "two_level_thread_scheduler_top_assert.svh"
module tlts_checker
  import tlts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  // A result holds until it is taken.
  `TLTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // The status field only carries defined codes.
  `TLTS_ASSERT_IMP(a_status_range, clk, rst_n, out_tvalid, out_tdata[10:9] <= ST_DONE)
  // Idle results report slot zero.
  `TLTS_ASSERT_IMP(a_idle_slot, clk, rst_n, out_tvalid && out_tdata[4], out_tdata[3:0] == 4'd0)
  // An accepted command closes the input side for the next cycle.
  `TLTS_ASSERT_NXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
endmodule

bind two_level_thread_scheduler_top tlts_checker u_tlts_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

/* tb/two_level_thread_scheduler_top_tb.sv */
// Self-checking testbench of the two-level thread scheduler with a built-in predictor.
`timescale 1ns / 1ps
module two_level_thread_scheduler_top_tb;
  import tlts_pkg::*;

  localparam int NSLOT = 16;
  localparam int STALL_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  two_level_thread_scheduler_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0] pad;
    event_t     ev;
    logic [1:0] status;
    logic [3:0] created;
    logic       idle;
    logic [3:0] running;
  } sched_result_t;

  // Scheduler state mirrored by the predictor.
  logic [15:0] quantum, main_ticks, raised_ticks;
  logic [1:0]  slot_state [NSLOT];
  logic        slot_high [NSLOT];
  logic [15:0] slot_left [NSLOT];
  logic [15:0] slot_budget [NSLOT];
  logic [16:0] slot_used [NSLOT];
  logic [15:0] slot_slice [NSLOT];
  int          low_fifo [$];
  int          high_q [$];
  int          disk_fifo [$];
  int          cur;
  bit          is_idle, is_done, started;

  sched_result_t expected_results [$];
  int  errors = 0;
  int  items_sent = 0;
  bit  send_gaps = 1'b1;
  bit  recv_gaps = 1'b1;
  bit  recv_hold = 1'b0;

  task automatic sched_reset();
    quantum = QuantumReset;
    main_ticks = MainReset;
    raised_ticks = RaisedReset;
    for (int i = 0; i < NSLOT; i++) begin
      slot_state[i] = SLOT_FREE;
      slot_high[i] = 1'b0;
      slot_left[i] = '0;
      slot_budget[i] = '0;
      slot_used[i] = '0;
      slot_slice[i] = quantum;
    end
    slot_state[0] = SLOT_READY;
    slot_left[0] = main_ticks;
    slot_budget[0] = main_ticks;
    low_fifo.delete();
    high_q.delete();
    disk_fifo.delete();
    cur = 0;
    is_idle = 0;
    is_done = 0;
    started = 0;
  endtask

  // Shortest remaining first; equal remaining keeps arrival order.
  function automatic void high_insert(int s);
    int p;
    p = 0;
    while (p < high_q.size() && slot_left[high_q[p]] <= slot_left[s]) p++;
    high_q.insert(p, s);
  endfunction

  function automatic void pick_next();
    is_idle = 0;
    if (high_q.size() > 0) cur = high_q.pop_front();
    else if (low_fifo.size() > 0) cur = low_fifo.pop_front();
    else if (disk_fifo.size() > 0) is_idle = 1;
    else is_done = 1;
  endfunction

  function automatic int live_threads();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (slot_state[i] != SLOT_FREE) n++;
    return n;
  endfunction

  function automatic sched_result_t schedule_cmd(logic [2:0] op, logic pri, logic [15:0] dur,
                                                 logic must_wait);
    sched_result_t res;
    int i, r;
    res = '0;
    res.ev = EV_NONE;
    res.status = ST_OK;
    started = 1;
    if (!is_done) begin
      case (op)
        OP_CREATE: begin
          for (i = 0; i < NSLOT; i++) if (slot_state[i] == SLOT_FREE) break;
          if (i == NSLOT) begin
            res.status = ST_FULL;
          end else begin
            res.created = i[3:0];
            slot_state[i] = SLOT_READY;
            slot_high[i] = pri;
            slot_budget[i] = dur;
            slot_left[i] = dur;
            slot_used[i] = '0;
            slot_slice[i] = quantum;
            if (!pri) begin
              low_fifo.push_back(i);
            end else if (is_idle) begin
              high_insert(i);
            end else if (!slot_high[cur]) begin
              slot_slice[cur] = quantum;
              low_fifo.push_back(cur);
              high_insert(i);
              pick_next();
              res.ev = EV_PREEMPT;
            end else if (slot_left[i] < slot_left[cur]) begin
              high_insert(cur);
              cur = i;
              res.ev = EV_PREEMPT;
            end else begin
              high_insert(i);
            end
          end
        end
        OP_TICK: begin
          if (is_idle) begin
            if (high_q.size() > 0 || low_fifo.size() > 0) begin
              pick_next();
              res.ev = EV_SWITCH;
            end
          end else begin
            r = cur;
            if (quantum > slot_left[r]) slot_slice[r] = slot_left[r];
            if (slot_used[r] > {1'b0, slot_budget[r]}) begin
              slot_state[r] = SLOT_FREE;
              pick_next();
              res.ev = EV_TIMEOUT;
            end else begin
              slot_used[r] = slot_used[r] + 17'd1;
              if (slot_left[r] > 0) slot_left[r]--;
              if (slot_left[r] == 0) begin
                slot_state[r] = SLOT_FREE;
                pick_next();
                res.ev = EV_FINISH;
              end else if (!slot_high[r]) begin
                if (slot_slice[r] > 0) slot_slice[r]--;
                if (slot_slice[r] == 0) begin
                  slot_slice[r] = quantum;
                  low_fifo.push_back(r);
                  pick_next();
                  res.ev = (cur != r) ? EV_SWITCH : EV_NONE;
                end
              end
            end
          end
        end
        OP_DWAIT: begin
          if (!is_idle && must_wait) begin
            slot_state[cur] = SLOT_WAIT;
            disk_fifo.push_back(cur);
            pick_next();
            res.ev = EV_BLOCK;
          end
        end
        OP_DDONE: begin
          if (disk_fifo.size() > 0) begin
            r = disk_fifo.pop_front();
            slot_state[r] = SLOT_READY;
            if (!slot_high[r]) low_fifo.push_back(r);
            else high_insert(r);
            res.ev = EV_WOKEN;
          end
        end
        OP_EXIT: begin
          if (!is_idle) begin
            slot_state[cur] = SLOT_FREE;
            pick_next();
            res.ev = EV_FINISH;
          end
        end
        OP_SETPRI: begin
          if (!is_idle) begin
            slot_high[cur] = pri;
            if (pri) slot_left[cur] = raised_ticks;
          end
        end
        default: ;
      endcase
    end
    if (is_done) res.status = ST_DONE;
    res.running = (!is_idle && !is_done) ? cur[3:0] : 4'd0;
    res.idle = is_idle;
    return res;
  endfunction

  task automatic send_cmd(logic [2:0] op, logic pri, logic [15:0] dur, logic must_wait);
    in_tdata = {3'b000, must_wait, dur, pri, op};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(schedule_cmd(op, pri, dur, must_wait));
    items_sent++;
    @(negedge clk);
    if (send_gaps && $urandom_range(99) < 30) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic end_burst();
    in_tvalid = 1'b0;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_QUANTUM: begin
        quantum = val;
        if (!started) for (int i = 0; i < NSLOT; i++) slot_slice[i] = val;
      end
      CFG_MAIN: begin
        main_ticks = val;
        if (!started) begin
          slot_left[0] = val;
          slot_budget[0] = val;
        end
      end
      CFG_RAISED: raised_ticks = val;
      default: ;
    endcase
  endtask

  // Random command; keeps at least a few threads alive so the block never runs dry.
  task automatic send_random();
    int w;
    logic [2:0] op;
    logic [15:0] dur;
    w = $urandom_range(99);
    if (w < 20) op = OP_CREATE;
    else if (w < 60) op = OP_TICK;
    else if (w < 72) op = OP_DWAIT;
    else if (w < 84) op = OP_DDONE;
    else if (w < 91) op = OP_EXIT;
    else if (w < 97) op = OP_SETPRI;
    else op = 3'($urandom_range(6, 7));
    if (live_threads() <= 2) op = OP_CREATE;
    dur = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
    send_cmd(op, 1'($urandom), dur, ($urandom_range(3) != 0));
  endtask

  task automatic test_directed();
    write_reg(CFG_QUANTUM, 16'd3);
    write_reg(CFG_MAIN, 16'd40);
    write_reg(CFG_RAISED, 16'd10);
    send_cmd(OP_CREATE, 1'b1, 16'd5, 1'b0);
    send_cmd(OP_CREATE, 1'b1, 16'd2, 1'b0);
    send_cmd(OP_CREATE, 1'b1, 16'd9, 1'b0);
    send_cmd(OP_CREATE, 1'b1, 16'd9, 1'b0);
    repeat (3) send_cmd(OP_TICK, 1'b0, 16'd0, 1'b0);
    send_cmd(OP_CREATE, 1'b0, 16'd0, 1'b0);
    send_cmd(OP_DWAIT, 1'b0, 16'd0, 1'b0);
    send_cmd(OP_DWAIT, 1'b0, 16'd0, 1'b1);
    send_cmd(OP_DWAIT, 1'b0, 16'd0, 1'b1);
    repeat (3) send_cmd(OP_DDONE, 1'b0, 16'd0, 1'b0);
    send_cmd(OP_SETPRI, 1'b1, 16'd0, 1'b0);
    send_cmd(OP_EXIT, 1'b0, 16'd0, 1'b0);
    send_cmd(3'd6, 1'b1, 16'hFFFF, 1'b1);
    send_cmd(3'd7, 1'b0, 16'd0, 1'b0);
    send_cmd(OP_CREATE, 1'b1, 16'hFFFF, 1'b1);
    send_cmd(OP_CREATE, 1'b0, 16'hAAAA, 1'b0);
    send_cmd(OP_CREATE, 1'b0, 16'h5555, 1'b0);
    while (live_threads() < NSLOT) send_cmd(OP_CREATE, 1'b0, 16'd1, 1'b0);
    send_cmd(OP_CREATE, 1'b1, 16'd1, 1'b0);
    end_burst();
  endtask

  task automatic test_random(int n);
    repeat (n) send_random();
    end_burst();
  endtask

  // Receiver holds off for a long stretch while commands keep being offered.
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(negedge clk);
        recv_hold = 1'b0;
      end
      repeat (30) send_random();
    join
    end_burst();
  endtask

  task automatic test_no_gaps(int n);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    repeat (n) send_random();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    end_burst();
  endtask

  // Empties the table: wake waiters, dispatch them, exit everything; then sends a create and a tick.
  task automatic test_run_to_done();
    int guard;
    guard = 0;
    while (!is_done && guard < 200) begin
      if (is_idle && high_q.size() == 0 && low_fifo.size() == 0)
        send_cmd(OP_DDONE, 1'b0, 16'd0, 1'b0);
      else if (is_idle)
        send_cmd(OP_TICK, 1'b0, 16'd0, 1'b0);
      else
        send_cmd(OP_EXIT, 1'b0, 16'd0, 1'b0);
      guard++;
    end
    send_cmd(OP_CREATE, 1'b1, 16'd3, 1'b0);
    send_cmd(OP_TICK, 1'b0, 16'd0, 1'b0);
    end_burst();
  endtask

  always @(negedge clk) begin
    if (!rst_n || recv_hold) out_tready <= 1'b0;
    else out_tready <= !(recv_gaps && $urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    sched_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = sched_result_t'(out_tdata);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.running !== want.running || got.idle !== want.idle ||
            got.created !== want.created || got.status !== want.status ||
            got.ev !== want.ev) begin
          $display("%0t: mismatch expected run=%0d idle=%0b new=%0d st=%0d ev=%0d",
                   $time, want.running, want.idle, want.created, want.status, want.ev);
          $display("%0t:          actual   run=%0d idle=%0b new=%0d st=%0d ev=%0d",
                   $time, got.running, got.idle, got.created, got.status, got.ev);
          errors++;
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    sched_reset();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    write_reg(CFG_QUANTUM, 16'd1);
    write_reg(CFG_RAISED, 16'd0);
    test_random(150);
    write_reg(CFG_QUANTUM, 16'd65535);
    write_reg(CFG_RAISED, 16'd65535);
    write_reg(CFG_MAIN, 16'd0);
    test_random(120);
    write_reg(CFG_QUANTUM, 16'd4);
    write_reg(CFG_RAISED, 16'd6);
    test_backpressure();
    test_no_gaps(150);
    write_reg(CFG_QUANTUM, 16'd2);
    write_reg(CFG_MAIN, 16'd65535);
    write_reg(CFG_RAISED, 16'd195);
    test_random(250);
    test_run_to_done();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+src
src/tlts_pkg.sv
src/two_level_thread_scheduler_top.sv
src/tlts_checker.sv
tb/two_level_thread_scheduler_top_tb.sv
